@@ hw/rtl/lie_pkg.sv @@
// shared types and constants for the lagrange interpolation evaluator
`default_nettype none

package lie_pkg;

    // dividend width: 64-bit magnitude times 33-bit difference
    localparam int unsigned DVD_W = 97;
    // divisor width: magnitude of a 33-bit difference
    localparam int unsigned DSR_W = 33;
    // step counter width for the bit-serial divide
    localparam int unsigned DCNT_W = 7;

    // 1.0 in unsigned Q32.32
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    // cap on one term magnitude in unsigned Q48.16
    localparam logic [63:0] TERM_CAP = 64'h0100_0000_0000_0000;

    // input kind carried in tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // sequencer states
    typedef enum logic [17:0] {
        S_IDLE = 18'b00_0000_0000_0000_0001,
        S_DRI  = 18'b00_0000_0000_0000_0010,
        S_DLI  = 18'b00_0000_0000_0000_0100,
        S_DRJ  = 18'b00_0000_0000_0000_1000,
        S_DCJ  = 18'b00_0000_0000_0001_0000,
        S_ERI  = 18'b00_0000_0000_0010_0000,
        S_ELI  = 18'b00_0000_0000_0100_0000,
        S_ERJ  = 18'b00_0000_0000_1000_0000,
        S_EFJ  = 18'b00_0000_0001_0000_0000,
        S_M0   = 18'b00_0000_0010_0000_0000,
        S_M1   = 18'b00_0000_0100_0000_0000,
        S_DST  = 18'b00_0000_1000_0000_0000,
        S_DIV  = 18'b00_0001_0000_0000_0000,
        S_TM0  = 18'b00_0010_0000_0000_0000,
        S_TM1  = 18'b00_0100_0000_0000_0000,
        S_ACC  = 18'b00_1000_0000_0000_0000,
        S_FIN  = 18'b01_0000_0000_0000_0000,
        S_OUT  = 18'b10_0000_0000_0000_0000
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/lie_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module lie_divider
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [lie_pkg::DVD_W-1:0] dividend,
    input  wire logic [lie_pkg::DSR_W-1:0] divisor,
    output logic                           done,
    output logic [lie_pkg::DVD_W-1:0]      quotient
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [lie_pkg::DCNT_W-1:0]  cnt_reg;
    logic [lie_pkg::DSR_W-1:0]   rem_reg;
    logic [lie_pkg::DSR_W-1:0]   dsr_reg;
    logic [lie_pkg::DVD_W-1:0]   dvd_reg;
    logic [lie_pkg::DSR_W:0]     rem_shift;
    logic [lie_pkg::DSR_W:0]     rem_diff;
    logic                        ge;

    // shift in the next dividend bit and try the subtract
    assign rem_shift = {rem_reg, dvd_reg[lie_pkg::DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign ge        = rem_shift >= {1'b0, dsr_reg};

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= lie_pkg::DCNT_W'(lie_pkg::DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - lie_pkg::DCNT_W'(1);
                if (cnt_reg == lie_pkg::DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[lie_pkg::DSR_W-1:0] : rem_shift[lie_pkg::DSR_W-1:0];
            dvd_reg <= {dvd_reg[lie_pkg::DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lagrange_interpolation_eval_core.sv @@
// lagrange interpolation evaluator top level, signed Q16.16
//
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  tuser mode, tdata node index, x, y, z
// m_*       out  m_tvalid/m_tready  tdata p(z), tuser error and overflow flags
// cfg_*     in   cfg_wr_en          node count
//
// a load word is written into the node table while idle. an evaluate word first
// compares node pairs, then runs n*(n-1) factors, each set by the 97-step
// bit-serial divider, plus a term multiply and accumulate per node and a final
// saturation step at the end. one 32x32 multiplier is shared by all
// products. s_tready is high only while idle; a result waits in the output
// register until taken. reset clears control state; the node table is undefined.
`default_nettype none

module lagrange_interpolation_eval_core
#(
    parameter int MAX_NODES = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [3:0]   cfg_wr_data,     // node_count
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,         // node_index, node_abscissa, node_value, point_z
    input  wire logic         s_tuser,         // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,         // poly_value
    output logic [1:0]        m_tuser          // duplicate_node_error, overflow_flag
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = $clog2(MAX_NODES);

    lie_pkg::state_t state_reg, state_next;

    logic [3:0]       node_count_reg;
    logic [CNT_W-1:0] n_reg, i_reg, j_reg, i_inc, j_inc, n_clamp;
    logic [IDX_W-1:0] rd_addr;

    logic [31:0] x_mem [MAX_NODES];
    logic [31:0] y_mem [MAX_NODES];

    logic [31:0]  rd_x_reg, rd_y_reg, z_reg, xi_reg, yi_reg;
    logic [63:0]  mag_reg;
    logic         neg_reg, ovf_reg;
    logic [32:0]  dmag_reg, emag_reg;
    logic [127:0] acc_reg;
    logic [63:0]  sum_reg;
    logic [31:0]  out_data_reg;
    logic         out_dup_reg, out_ovf_reg;

    logic [2:0]   in_index;
    logic [31:0]  in_x, in_y, in_z, slot_ext;
    logic         slot_ok;
    logic [32:0]  d_diff, e_diff;
    logic [31:0]  ymag;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic         div_start, div_done, div_big;
    logic [lie_pkg::DVD_W-1:0] div_q;
    logic [95:0]  tm_full;
    logic         tm_cap;
    logic [63:0]  tm;
    logic         sat_hi, sat_lo;

    // input word unpack
    assign in_index = s_tdata[2:0];
    assign in_x     = s_tdata[34:3];
    assign in_y     = s_tdata[66:35];
    assign in_z     = s_tdata[98:67];
    assign slot_ext = 32'(in_index);
    assign slot_ok  = slot_ext < 32'(MAX_NODES);

    assign i_inc = i_reg + CNT_W'(1);
    assign j_inc = j_reg + CNT_W'(1);

    // node count in use, clamped to 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == 4'd0)
            n_clamp = CNT_W'(1);
        else if (32'(node_count_reg) > 32'(MAX_NODES))
            n_clamp = CNT_W'(MAX_NODES);
        else
            n_clamp = CNT_W'(node_count_reg);
    end

    // table read address
    always_comb
    begin
        if (state_reg == lie_pkg::S_DRI || state_reg == lie_pkg::S_ERI)
            rd_addr = i_reg[IDX_W-1:0];
        else
            rd_addr = j_reg[IDX_W-1:0];
    end

    // differences and magnitudes
    assign d_diff = {z_reg[31], z_reg} - {rd_x_reg[31], rd_x_reg};
    assign e_diff = {xi_reg[31], xi_reg} - {rd_x_reg[31], rd_x_reg};
    assign ymag   = yi_reg[31] ? (32'd0 - yi_reg) : yi_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            lie_pkg::S_M0:
            begin
                mul_a = mag_reg[31:0];
                mul_b = dmag_reg[31:0];
            end
            lie_pkg::S_M1:
            begin
                mul_a = mag_reg[63:32];
                mul_b = dmag_reg[31:0];
            end
            lie_pkg::S_TM0:
            begin
                mul_a = ymag;
                mul_b = mag_reg[31:0];
            end
            lie_pkg::S_TM1:
            begin
                mul_a = ymag;
                mul_b = mag_reg[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // factor divide
    assign div_start = (state_reg == lie_pkg::S_DST);

    lie_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[lie_pkg::DVD_W-1:0]),
        .divisor  (emag_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_big = |div_q[lie_pkg::DVD_W-1:64];

    // term truncation and cap
    assign tm_full = acc_reg[127:32];
    assign tm_cap  = tm_full > 96'(lie_pkg::TERM_CAP);
    assign tm      = tm_cap ? lie_pkg::TERM_CAP : tm_full[63:0];

    // final saturation
    assign sat_hi = $signed(sum_reg) > 64'sd2147483647;
    assign sat_lo = $signed(sum_reg) < -64'sd2147483648;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lie_pkg::S_IDLE:
                if (s_tvalid && s_tuser == lie_pkg::MODE_EVAL)
                    state_next = lie_pkg::S_DRI;
            lie_pkg::S_DRI:
                state_next = lie_pkg::S_DLI;
            lie_pkg::S_DLI:
                state_next = (i_inc >= n_reg) ? lie_pkg::S_ERI : lie_pkg::S_DRJ;
            lie_pkg::S_DRJ:
                state_next = lie_pkg::S_DCJ;
            lie_pkg::S_DCJ:
                if (rd_x_reg == xi_reg)
                    state_next = lie_pkg::S_OUT;
                else if (j_inc >= n_reg)
                    state_next = lie_pkg::S_DRI;
                else
                    state_next = lie_pkg::S_DRJ;
            lie_pkg::S_ERI:
                state_next = lie_pkg::S_ELI;
            lie_pkg::S_ELI:
                state_next = lie_pkg::S_ERJ;
            lie_pkg::S_ERJ:
                if (j_reg == n_reg)
                    state_next = lie_pkg::S_TM0;
                else if (j_reg != i_reg)
                    state_next = lie_pkg::S_EFJ;
            lie_pkg::S_EFJ:
                state_next = lie_pkg::S_M0;
            lie_pkg::S_M0:
                state_next = lie_pkg::S_M1;
            lie_pkg::S_M1:
                state_next = lie_pkg::S_DST;
            lie_pkg::S_DST:
                state_next = lie_pkg::S_DIV;
            lie_pkg::S_DIV:
                if (div_done)
                    state_next = lie_pkg::S_ERJ;
            lie_pkg::S_TM0:
                state_next = lie_pkg::S_TM1;
            lie_pkg::S_TM1:
                state_next = lie_pkg::S_ACC;
            lie_pkg::S_ACC:
                state_next = (i_inc == n_reg) ? lie_pkg::S_FIN : lie_pkg::S_ERI;
            lie_pkg::S_FIN:
                state_next = lie_pkg::S_OUT;
            lie_pkg::S_OUT:
                if (m_tready)
                    state_next = lie_pkg::S_IDLE;
            default:
                state_next = lie_pkg::S_IDLE;
        endcase
    end

    // control registers and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lie_pkg::S_IDLE;
            node_count_reg <= 4'd1;
            n_reg          <= CNT_W'(1);
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                node_count_reg <= cfg_wr_data;
            case (state_reg)
                lie_pkg::S_IDLE:
                begin
                    n_reg <= n_clamp;
                    i_reg <= '0;
                end
                lie_pkg::S_DLI:
                begin
                    j_reg <= i_inc;
                    if (i_inc >= n_reg)
                        i_reg <= '0;
                end
                lie_pkg::S_DCJ:
                    if (j_inc >= n_reg)
                        i_reg <= i_inc;
                    else
                        j_reg <= j_inc;
                lie_pkg::S_ELI:
                    j_reg <= '0;
                lie_pkg::S_ERJ:
                    if (j_reg != n_reg && j_reg == i_reg)
                        j_reg <= j_inc;
                lie_pkg::S_DIV:
                    if (div_done)
                        j_reg <= j_inc;
                lie_pkg::S_ACC:
                    i_reg <= i_inc;
                default:
                begin
                end
            endcase
        end
    end

    // node table write and registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == lie_pkg::S_IDLE && s_tvalid && s_tuser == lie_pkg::MODE_LOAD && slot_ok)
        begin
            x_mem[slot_ext[IDX_W-1:0]] <= in_x;
            y_mem[slot_ext[IDX_W-1:0]] <= in_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lie_pkg::S_IDLE:
            begin
                z_reg   <= in_z;
                ovf_reg <= 1'b0;
                sum_reg <= '0;
            end
            lie_pkg::S_DLI:
                xi_reg <= rd_x_reg;
            lie_pkg::S_DCJ:
            begin
                out_data_reg <= '0;
                out_dup_reg  <= 1'b1;
                out_ovf_reg  <= 1'b0;
            end
            lie_pkg::S_ELI:
            begin
                xi_reg  <= rd_x_reg;
                yi_reg  <= rd_y_reg;
                mag_reg <= lie_pkg::ONE_Q32;
                neg_reg <= 1'b0;
            end
            lie_pkg::S_EFJ:
            begin
                neg_reg  <= neg_reg ^ d_diff[32] ^ e_diff[32];
                dmag_reg <= d_diff[32] ? (33'd0 - d_diff) : d_diff;
                emag_reg <= e_diff[32] ? (33'd0 - e_diff) : e_diff;
            end
            lie_pkg::S_M0:
                acc_reg <= 128'(mul_p) + (dmag_reg[32] ? {32'd0, mag_reg, 32'd0} : 128'd0);
            lie_pkg::S_M1:
                acc_reg <= acc_reg + {32'd0, mul_p, 32'd0};
            lie_pkg::S_DIV:
                if (div_done)
                begin
                    mag_reg <= div_big ? {64{1'b1}} : div_q[63:0];
                    ovf_reg <= ovf_reg | div_big;
                end
            lie_pkg::S_TM0:
            begin
                acc_reg <= 128'(mul_p);
                neg_reg <= neg_reg ^ yi_reg[31];
            end
            lie_pkg::S_TM1:
                acc_reg <= acc_reg + {32'd0, mul_p, 32'd0};
            lie_pkg::S_ACC:
            begin
                sum_reg <= neg_reg ? (sum_reg - tm) : (sum_reg + tm);
                ovf_reg <= ovf_reg | tm_cap;
            end
            lie_pkg::S_FIN:
            begin
                if (sat_hi)
                    out_data_reg <= 32'h7FFF_FFFF;
                else if (sat_lo)
                    out_data_reg <= 32'h8000_0000;
                else
                    out_data_reg <= sum_reg[31:0];
                out_dup_reg <= 1'b0;
                out_ovf_reg <= ovf_reg | sat_hi | sat_lo;
            end
            default:
            begin
            end
        endcase
    end

    // handshake and output word
    assign s_tready = (state_reg == lie_pkg::S_IDLE);
    assign m_tvalid = (state_reg == lie_pkg::S_OUT);
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_ovf_reg, out_dup_reg};

endmodule

`default_nettype wire
